FILE: src/hpt_pkg.sv
package hpt_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int COEF_BITS = 32;
   localparam int REG_BITS = 64;
   localparam int NUM_REGS = 8;
   localparam int IDX_BITS = 3;
   localparam logic [IDX_BITS-1:0] REG_R0_C01 = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_R0_C23 = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_R1_C01 = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_R1_C23 = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_R2_C01 = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_R2_C23 = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_R3_C01 = 3'd6;
   localparam logic [IDX_BITS-1:0] REG_R3_C23 = 3'd7;
   localparam logic [REG_BITS-1:0] RST_R0_C01 = 64'h0000_0000_0001_0000;
   localparam logic [REG_BITS-1:0] RST_R1_C01 = 64'h0001_0000_0000_0000;
   localparam logic [REG_BITS-1:0] RST_R2_C23 = 64'h0000_0000_0001_0000;
   localparam logic [REG_BITS-1:0] RST_R3_C23 = 64'h0001_0000_0000_0000;
   localparam logic [REG_BITS-1:0] RST_ZERO = 64'h0;
endpackage

FILE: src/hpt_if.sv
interface hpt_req_if #(parameter int COORD_BITS = 32) (input logic clock);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface hpt_rsp_if #(parameter int COORD_BITS = 32) (input logic clock);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] proj_x;
   logic signed [COORD_BITS-1:0] proj_y;
   logic signed [COORD_BITS-1:0] proj_z;
   logic w_zero;
   logic saturated;
   modport source (output valid, proj_x, proj_y, proj_z, w_zero, saturated, input ready);
   modport sink (input valid, proj_x, proj_y, proj_z, w_zero, saturated, output ready);
endinterface

interface hpt_csr_if (input logic clock);
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/hpt_div.sv
// Pipelined restoring divider: one quotient bit per stage, a full bit-serial
// array. Magnitudes in, magnitude quotient out, with a sideband that rides along.
module hpt_div #(
   parameter int NUM_BITS = 64,
   parameter int DEN_BITS = 64,
   parameter int SIDE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [NUM_BITS-1:0]   in_num,
   input  logic [DEN_BITS-1:0]   in_den,
   input  logic [SIDE_BITS-1:0]  in_side,
   output logic                  out_valid,
   output logic [NUM_BITS-1:0]   out_quot,
   output logic [SIDE_BITS-1:0]  out_side
);
   logic                 vld_ff  [NUM_BITS+1];
   logic [NUM_BITS-1:0]  num_ff  [NUM_BITS+1];
   logic [DEN_BITS:0]    rem_ff  [NUM_BITS+1];
   logic [DEN_BITS-1:0]  den_ff  [NUM_BITS+1];
   logic [SIDE_BITS-1:0] side_ff [NUM_BITS+1];

   // stage 0 takes the operands
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         num_ff[0]  <= in_num;
         rem_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   // each stage shifts in one numerator bit and makes one quotient bit
   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      logic [DEN_BITS+1:0] trial;
      logic [DEN_BITS:0]   shifted;
      logic [DEN_BITS:0]   rem_in;
      logic [NUM_BITS-1:0] num_in;
      always_comb begin
         shifted = {rem_ff[s][DEN_BITS-1:0], num_ff[s][NUM_BITS-1]};
         trial   = {1'b0, shifted} - {2'b00, den_ff[s]};
         num_in  = {num_ff[s][NUM_BITS-2:0], 1'b0};
         if (!trial[DEN_BITS+1]) begin
            rem_in = trial[DEN_BITS:0];
            num_in[0] = 1'b1;
         end else begin
            rem_in = shifted;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            num_ff[s+1]  <= num_in;
            rem_ff[s+1]  <= rem_in;
            den_ff[s+1]  <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[NUM_BITS];
   assign out_quot  = num_ff[NUM_BITS];
   assign out_side  = side_ff[NUM_BITS];
endmodule

FILE: src/homogeneous_point_transform.sv
// Homogeneous point transform with perspective divide.
// req_ carries one point (x, y, z) in signed fixed point per beat; it is taken
// as (x, y, z, 1), multiplied by the 4x4 matrix held in the csr_ registers,
// and x, y, z are divided by w. rsp_ returns the projected point per beat,
// with w_zero (w exactly zero, coordinates zero) and saturated (a quotient
// was clamped to the coordinate range).
// csr_ writes one 64-bit register (two 32-bit coefficients) per beat; every
// 3-bit index names a register. Write only while the pipe is empty.
// Throughput: one point per cycle while the pipe is not held. Pipeline: 5 stages
// of capture, multiply, sum and sign, then the divider array, an input stage
// plus one stage per quotient bit (COORD_BITS + 32 + 2 + FRAC_BITS bits), then
// one output stage. Reset loads the identity matrix and empties the pipe.
// When rsp_valid is high and rsp_ready is low the whole pipe holds; req_ready
// is high while the output register is empty or rsp_ready is high, and an
// output register keeps the finished beat in place.
module homogeneous_point_transform #(
   parameter int COORD_BITS = hpt_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   hpt_req_if.sink   req,
   hpt_rsp_if.source rsp,
   hpt_csr_if.sink   csr
);
   import hpt_pkg::*;

   localparam int PROD_BITS = COORD_BITS + COEF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int MAG_BITS  = SUM_BITS;
   localparam int QNUM_BITS = MAG_BITS + FRAC_BITS;
   localparam int SIDE_BITS = 4;

   logic [REG_BITS-1:0] regs_ff [NUM_REGS];
   logic advance;

   // registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_R0_C01] <= RST_R0_C01;
         regs_ff[REG_R0_C23] <= RST_ZERO;
         regs_ff[REG_R1_C01] <= RST_R1_C01;
         regs_ff[REG_R1_C23] <= RST_ZERO;
         regs_ff[REG_R2_C01] <= RST_ZERO;
         regs_ff[REG_R2_C23] <= RST_R2_C23;
         regs_ff[REG_R3_C01] <= RST_ZERO;
         regs_ff[REG_R3_C23] <= RST_R3_C23;
      end else if (csr.valid) begin
         regs_ff[csr.index] <= csr.data;
      end
   end

   // whole pipe moves together; output register frees when taken
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // stage 1: capture point
   logic v1_ff;
   logic signed [COORD_BITS-1:0] p_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req.valid;
      if (advance) begin
         p_ff[0] <= req.point_x;
         p_ff[1] <= req.point_y;
         p_ff[2] <= req.point_z;
      end
   end

   // stage 2: twelve products, one multiplier each
   logic v2_ff;
   logic signed [PROD_BITS-1:0] m_ff [4][3];
   logic signed [SUM_BITS-1:0]  t_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               m_ff[r][c] <= PROD_BITS'($signed(
                  regs_ff[2*r + c/2][COEF_BITS*(c%2) +: COEF_BITS]) * p_ff[c]);
            end
            t_ff[r] <= SUM_BITS'($signed(regs_ff[2*r+1][REG_BITS-1 -: COEF_BITS]))
                       <<< FRAC_BITS;
         end
      end
   end

   // stage 3: pairwise sums
   logic v3_ff;
   logic signed [SUM_BITS-1:0] a_ff [4];
   logic signed [SUM_BITS-1:0] b_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            a_ff[r] <= SUM_BITS'(m_ff[r][0]) + SUM_BITS'(m_ff[r][1]);
            b_ff[r] <= SUM_BITS'(m_ff[r][2]) + t_ff[r];
         end
      end
   end

   // stage 4: row sums
   logic v4_ff;
   logic signed [SUM_BITS-1:0] s_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         for (int r = 0; r < 4; r++) s_ff[r] <= a_ff[r] + b_ff[r];
      end
   end

   // stage 5: magnitudes and signs, w zero test
   logic v5_ff;
   logic [MAG_BITS-1:0] nmag_ff [3];
   logic [MAG_BITS-1:0] wmag_ff;
   logic                neg_ff [3];
   logic                wz_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            nmag_ff[r] <= s_ff[r][SUM_BITS-1] ? MAG_BITS'(-s_ff[r]) : MAG_BITS'(s_ff[r]);
            neg_ff[r]  <= s_ff[r][SUM_BITS-1] ^ s_ff[3][SUM_BITS-1];
         end
         wmag_ff <= s_ff[3][SUM_BITS-1] ? MAG_BITS'(-s_ff[3]) : MAG_BITS'(s_ff[3]);
         wz_ff   <= (s_ff[3] == '0);
      end
   end

   // three divider arrays
   logic                  dv   [3];
   logic [QNUM_BITS-1:0]  quot [3];
   logic [SIDE_BITS-1:0]  side [3];
   for (genvar k = 0; k < 3; k++) begin : g_div
      hpt_div #(
         .NUM_BITS(QNUM_BITS), .DEN_BITS(MAG_BITS), .SIDE_BITS(SIDE_BITS)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (v5_ff),
         .in_num   ({nmag_ff[k], {FRAC_BITS{1'b0}}}),
         .in_den   (wz_ff ? MAG_BITS'(1) : wmag_ff),
         .in_side  ({2'b00, wz_ff, neg_ff[k]}),
         .out_valid(dv[k]),
         .out_quot (quot[k]),
         .out_side (side[k])
      );
   end

   // output stage: sign, saturate, zero on w zero
   localparam logic [QNUM_BITS-1:0] PMAX = QNUM_BITS'((64'd1 << (COORD_BITS-1)) - 64'd1);
   logic [COORD_BITS-1:0] res_in [3];
   logic                  sat_in;
   always_comb begin
      logic [QNUM_BITS-1:0] lim;
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         lim = side[k][0] ? PMAX + QNUM_BITS'(1) : PMAX;
         if (side[0][1]) begin
            res_in[k] = '0;
         end else if (quot[k] > lim) begin
            sat_in = 1'b1;
            res_in[k] = side[k][0] ? COORD_BITS'(-lim) : COORD_BITS'(lim);
         end else begin
            res_in[k] = side[k][0] ? COORD_BITS'(-quot[k]) : COORD_BITS'(quot[k]);
         end
      end
   end

   logic                  ov_ff;
   logic [COORD_BITS-1:0] o_ff [3];
   logic                  wz_out_ff, sat_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (advance) ov_ff <= dv[0];
      if (advance) begin
         for (int k = 0; k < 3; k++) o_ff[k] <= res_in[k];
         wz_out_ff <= side[0][1];
         sat_ff    <= sat_in;
      end
   end

   assign rsp.valid     = ov_ff;
   assign rsp.proj_x    = o_ff[0];
   assign rsp.proj_y    = o_ff[1];
   assign rsp.proj_z    = o_ff[2];
   assign rsp.w_zero    = wz_out_ff;
   assign rsp.saturated = sat_ff;
endmodule

FILE: src/hpt_checker.sv
module hpt_checker #(
   parameter int COORD_BITS = 32
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic w_zero,
   input logic saturated,
   input logic [COORD_BITS-1:0] proj_x
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp beat dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("req taken while stalled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && w_zero |-> !saturated && proj_x == '0) else $error("w zero flags");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp after reset");
endmodule

bind homogeneous_point_transform hpt_checker #(.COORD_BITS(COORD_BITS)) u_hpt_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .w_zero(rsp.w_zero), .saturated(rsp.saturated), .proj_x(rsp.proj_x)
);
